// ===== hw/rtl/bpsa_pkg.sv =====
// Shared types, codes and constants of the bitmap page slot allocator.
package bpsa_pkg;

  localparam int MAX_SLOTS_DEF  = 256;
  localparam int PAGE_SHIFT_DEF = 12;
  localparam int ADDR_W         = 48;
  localparam int ID_W           = 32;
  localparam int PAGES_W        = 9;
  localparam int ESHIFT_W       = 4;
  localparam int CFG_IDX_W      = 2;
  // Objects may not start inside the 32-byte page header.
  localparam int HDR_SHIFT      = 5;

  // Operation codes
  localparam logic [1:0] FN_ALLOC = 2'd0;
  localparam logic [1:0] FN_FREE  = 2'd1;
  localparam logic [1:0] FN_CHECK = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_PAGES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ELEM_SHIFT   = 2'd2;

  localparam logic [PAGES_W-1:0]  RESET_PAGES  = 9'd256;
  localparam logic [ESHIFT_W-1:0] RESET_ESHIFT = 4'd5;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SLOT  = 2'd1;
  localparam logic [1:0] ST_BAD_FREE = 2'd2;
  localparam logic [1:0] ST_REJECT   = 2'd3;

  typedef struct packed {
    logic [1:0]        func;
    logic [ADDR_W-1:0] page_addr;
    logic [ID_W-1:0]   obj_id;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] result_addr;
    logic [1:0]        status;
  } rsp_t;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_HINT,
    CUR_OFS,
    CUR_INC,
    CUR_DEC
  } cur_op_t;

  typedef enum logic [2:0] {
    RES_ALLOC_OK,
    RES_FREE_OK,
    RES_CHECK_OK,
    RES_NO_SLOT,
    RES_BAD_FREE,
    RES_REJECT
  } res_kind_t;

  // Controller to datapath
  typedef struct packed {
    logic      load_op;
    cur_op_t   cur_op;
    logic      sl_load;
    logic      ptr_load;
    logic      off_ptr;
    logic      wr_alloc;
    logic      wr_free;
    logic      hu_dn;
    logic      hu_clear;
    logic      res_load;
    res_kind_t res_kind;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hint_oob;
    logic up_hit;
    logic up_last;
    logic off_bad;
    logic bit_free;
    logic sl_is_hu;
    logic sl_zero;
    logic dn_hit;
    logic cur_zero;
    logic lim_bad;
    logic hdr_bad;
  } sts_t;

endpackage

// ===== hw/rtl/bpsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bpsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/bpsa_ctrl.sv =====
// Sequencer for alloc, free and check transactions.
module bpsa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [1:0]      func,
  input  bpsa_pkg::sts_t  sts,
  output bpsa_pkg::cmd_t  cmd,
  output logic            busy,
  output logic            done
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_START,
    S_A_RD,
    S_A_EV,
    S_F_ADDR,
    S_F_RD,
    S_F_EV,
    S_D_RD,
    S_D_EV,
    S_C_LIM,
    S_C_ADDR,
    S_C_RD,
    S_C_EV
  } state_t;

  state_t state;
  state_t state_next;
  logic   done_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    done_next    = 1'b0;
    cmd          = '0;
    cmd.cur_op   = bpsa_pkg::CUR_HOLD;
    cmd.res_kind = bpsa_pkg::RES_REJECT;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load_op = 1'b1;
          unique case (func)
            bpsa_pkg::FN_ALLOC: state_next = S_A_START;
            bpsa_pkg::FN_FREE:  state_next = S_F_ADDR;
            bpsa_pkg::FN_CHECK: state_next = S_C_LIM;
            default: begin
              cmd.res_load = 1'b1;
              cmd.res_kind = bpsa_pkg::RES_REJECT;
              done_next    = 1'b1;
            end
          endcase
        end
      end
      S_A_START: begin
        if (sts.hint_oob) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = bpsa_pkg::RES_NO_SLOT;
          done_next    = 1'b1;
          state_next   = S_IDLE;
        end else begin
          cmd.cur_op = bpsa_pkg::CUR_HINT;
          state_next = S_A_RD;
        end
      end
      S_A_RD: state_next = S_A_EV;
      S_A_EV: begin
        if (sts.up_hit) begin
          cmd.wr_alloc = 1'b1;
          cmd.res_load = 1'b1;
          cmd.res_kind = bpsa_pkg::RES_ALLOC_OK;
          done_next    = 1'b1;
          state_next   = S_IDLE;
        end else if (sts.up_last) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = bpsa_pkg::RES_NO_SLOT;
          done_next    = 1'b1;
          state_next   = S_IDLE;
        end else begin
          cmd.cur_op = bpsa_pkg::CUR_INC;
          state_next = S_A_RD;
        end
      end
      S_F_ADDR: begin
        if (sts.off_bad) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = bpsa_pkg::RES_BAD_FREE;
          done_next    = 1'b1;
          state_next   = S_IDLE;
        end else begin
          cmd.sl_load = 1'b1;
          cmd.cur_op  = bpsa_pkg::CUR_OFS;
          state_next  = S_F_RD;
        end
      end
      S_F_RD: state_next = S_F_EV;
      S_F_EV: begin
        if (sts.bit_free) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = bpsa_pkg::RES_BAD_FREE;
          done_next    = 1'b1;
          state_next   = S_IDLE;
        end else begin
          cmd.wr_free = 1'b1;
          if (sts.sl_is_hu && !sts.sl_zero) begin
            state_next = S_D_RD;
          end else begin
            cmd.res_load = 1'b1;
            cmd.res_kind = bpsa_pkg::RES_FREE_OK;
            done_next    = 1'b1;
            state_next   = S_IDLE;
          end
        end
      end
      S_D_RD: state_next = S_D_EV;
      S_D_EV: begin
        if (sts.dn_hit || sts.cur_zero) begin
          cmd.hu_dn    = sts.dn_hit;
          cmd.hu_clear = !sts.dn_hit;
          cmd.res_load = 1'b1;
          cmd.res_kind = bpsa_pkg::RES_FREE_OK;
          done_next    = 1'b1;
          state_next   = S_IDLE;
        end else begin
          cmd.cur_op = bpsa_pkg::CUR_DEC;
          state_next = S_D_RD;
        end
      end
      S_C_LIM: begin
        cmd.ptr_load = 1'b1;
        if (sts.lim_bad) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = bpsa_pkg::RES_REJECT;
          done_next    = 1'b1;
          state_next   = S_IDLE;
        end else begin
          state_next = S_C_ADDR;
        end
      end
      S_C_ADDR: begin
        cmd.off_ptr = 1'b1;
        if (sts.hdr_bad || sts.off_bad) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = bpsa_pkg::RES_REJECT;
          done_next    = 1'b1;
          state_next   = S_IDLE;
        end else begin
          cmd.sl_load = 1'b1;
          cmd.cur_op  = bpsa_pkg::CUR_OFS;
          state_next  = S_C_RD;
        end
      end
      S_C_RD: state_next = S_C_EV;
      S_C_EV: begin
        cmd.res_load = 1'b1;
        cmd.res_kind = sts.bit_free ? bpsa_pkg::RES_REJECT : bpsa_pkg::RES_CHECK_OK;
        done_next    = 1'b1;
        state_next   = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

endmodule

// ===== hw/rtl/bpsa_dp.sv =====
// Datapath: registers, slot bitmap RAM, word searches and address arithmetic.
module bpsa_dp #(
  parameter int MAX_SLOTS  = bpsa_pkg::MAX_SLOTS_DEF,
  parameter int PAGE_SHIFT = bpsa_pkg::PAGE_SHIFT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bpsa_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [bpsa_pkg::ADDR_W-1:0]      cfg_wdata,
  input  bpsa_pkg::req_t                   in_item,
  input  bpsa_pkg::cmd_t                   cmd,
  output bpsa_pkg::sts_t                   sts,
  output bpsa_pkg::rsp_t                   out_item
);

  localparam int ADDR_W = bpsa_pkg::ADDR_W;
  localparam int WORD_W = (MAX_SLOTS < 16) ? 8 : 16;
  localparam int BIT_W  = $clog2(WORD_W);
  localparam int ROWS   = (MAX_SLOTS + WORD_W - 1) / WORD_W;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int DEPTH  = 1 << ROW_W;
  localparam int GIDX_W = ROW_W + BIT_W;
  localparam int IX_W   = GIDX_W + 1;
  localparam int N_W    = $clog2(MAX_SLOTS + 1);
  localparam int SLOT_W = $clog2(MAX_SLOTS);
  localparam int OFS_W  = ADDR_W - PAGE_SHIFT;
  localparam int LIM_W  = SLOT_W + 1 + PAGE_SHIFT;
  localparam int CMP_W  = (LIM_W > bpsa_pkg::ID_W) ? LIM_W : bpsa_pkg::ID_W;
  localparam logic [4:0]        PS5         = 5'(PAGE_SHIFT);
  localparam logic [ADDR_W-1:0] PG_OFS_ONES = (48'(1) << PAGE_SHIFT) - 48'(1);

  // Configuration
  logic [ADDR_W-1:0]             region_base;
  logic [bpsa_pkg::PAGES_W-1:0]  region_pages;
  logic [bpsa_pkg::ESHIFT_W-1:0] elem_shift;

  // Allocator state and working registers
  logic [N_W-1:0]    hint;
  logic [SLOT_W-1:0] hu;
  logic [DEPTH-1:0]  rvalid;
  bpsa_pkg::req_t    op;
  logic [ROW_W-1:0]  cur;
  logic [IX_W-1:0]   sl;
  logic [ADDR_W-1:0] ptr_q;
  logic              vr_q;

  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] eff;
  logic [WORD_W-1:0] wdata;
  logic              we;

  logic [N_W-1:0]    n;
  logic [IX_W-1:0]   n_ix;
  logic [IX_W-1:0]   nm1;
  logic [IX_W-1:0]   hint_ix;

  logic              up_first;
  logic              up_last;
  logic [WORD_W-1:0] cand;
  logic [BIT_W-1:0]  up_idx;
  logic [IX_W-1:0]   found_ix;
  logic              dn_first;
  logic [WORD_W-1:0] dcand;
  logic [BIT_W-1:0]  dn_idx;

  logic [ADDR_W-1:0] off_src;
  logic [ADDR_W-1:0] diff;
  logic [OFS_W-1:0]  ofs;

  logic              es_ok;
  logic [4:0]        sh;
  logic [CMP_W-1:0]  lim;
  logic [SLOT_W-1:0] m;
  logic [ADDR_W-1:0] span_keep;
  logic [ADDR_W-1:0] ptr_c;
  logic [ADDR_W-1:0] alloc_addr;

  // Effective slot count, clamped to 1..MAX_SLOTS
  always_comb begin
    if (region_pages == '0) begin
      n = N_W'(1);
    end else if (32'(region_pages) > 32'(MAX_SLOTS)) begin
      n = N_W'(MAX_SLOTS);
    end else begin
      n = N_W'(region_pages);
    end
  end

  assign n_ix    = IX_W'(n);
  assign nm1     = n_ix - IX_W'(1);
  assign hint_ix = IX_W'(hint);

  // Bitmap word; rows never written read as all available
  bpsa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (cur),
    .wdata (wdata),
    .raddr (cur),
    .rdata (rdata)
  );

  assign eff = vr_q ? rdata : '1;

  // Upward search: lowest available bit in [hint, n-1]
  assign up_first = (cur == hint_ix[GIDX_W-1:BIT_W]);
  assign up_last  = (cur == nm1[GIDX_W-1:BIT_W]);

  always_comb begin
    up_idx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      cand[i] = eff[i]
              && (!up_first || BIT_W'(i) >= hint_ix[BIT_W-1:0])
              && (!up_last  || BIT_W'(i) <= nm1[BIT_W-1:0]);
    end
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        up_idx = BIT_W'(i);
      end
    end
  end

  assign found_ix = IX_W'({cur, up_idx});

  // Downward search: highest used bit below the freed slot
  assign dn_first = (cur == sl[GIDX_W-1:BIT_W]);

  always_comb begin
    dn_idx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      dcand[i] = !eff[i] && (!dn_first || BIT_W'(i) < sl[BIT_W-1:0]);
    end
    for (int i = 0; i < WORD_W; i++) begin
      if (dcand[i]) begin
        dn_idx = BIT_W'(i);
      end
    end
  end

  // Shared offset unit: address relative to region base, in pages
  assign off_src = cmd.off_ptr ? ptr_q : op.page_addr;
  assign diff    = off_src - region_base;
  assign ofs     = diff[ADDR_W-1:PAGE_SHIFT];

  // Check: id limit and object address
  assign es_ok = ({1'b0, elem_shift} <= PS5);
  assign sh    = PS5 - {1'b0, elem_shift};
  assign lim   = es_ok ? ((CMP_W'(hu) + CMP_W'(1)) << sh) : '0;

  always_comb begin
    m = SLOT_W'(n - N_W'(1));
    m = m | (m >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    m = m | (m >> 8);
  end

  assign span_keep = ((ADDR_W'(m) << PAGE_SHIFT) | PG_OFS_ONES)
                   & ({ADDR_W{1'b1}} << elem_shift);
  assign ptr_c     = (ADDR_W'(op.obj_id) << elem_shift) | (region_base & ~span_keep);

  assign alloc_addr = region_base + (ADDR_W'(found_ix) << PAGE_SHIFT);

  // Write-back word
  assign we = cmd.wr_alloc || cmd.wr_free;

  always_comb begin
    wdata = eff;
    if (cmd.wr_alloc) begin
      wdata[up_idx] = 1'b0;
    end else begin
      wdata[sl[BIT_W-1:0]] = 1'b1;
    end
  end

  // Status to the controller
  always_comb begin
    sts          = '0;
    sts.hint_oob = (hint_ix >= n_ix);
    sts.up_hit   = |cand;
    sts.up_last  = up_last;
    sts.off_bad  = (off_src < region_base) || (ofs >= OFS_W'(n));
    sts.bit_free = eff[sl[BIT_W-1:0]];
    sts.sl_is_hu = (sl == IX_W'(hu));
    sts.sl_zero  = (sl == '0);
    sts.dn_hit   = |dcand;
    sts.cur_zero = (cur == '0);
    sts.lim_bad  = (CMP_W'(op.obj_id) > lim);
    sts.hdr_bad  = (ptr_q[PAGE_SHIFT-1:bpsa_pkg::HDR_SHIFT] == '0);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      region_base  <= '0;
      region_pages <= bpsa_pkg::RESET_PAGES;
      elem_shift   <= bpsa_pkg::RESET_ESHIFT;
      hint         <= '0;
      hu           <= '0;
      rvalid       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          bpsa_pkg::REG_REGION_BASE:  region_base  <= cfg_wdata;
          bpsa_pkg::REG_REGION_PAGES: region_pages <= cfg_wdata[bpsa_pkg::PAGES_W-1:0];
          bpsa_pkg::REG_ELEM_SHIFT:   elem_shift   <= cfg_wdata[bpsa_pkg::ESHIFT_W-1:0];
          default: ;
        endcase
      end
      if (we) begin
        rvalid[cur] <= 1'b1;
      end
      if (cmd.wr_alloc) begin
        hint <= N_W'(found_ix + IX_W'(1));
        if (found_ix > IX_W'(hu)) begin
          hu <= SLOT_W'(found_ix);
        end
      end
      if (cmd.wr_free && (sl < hint_ix)) begin
        hint <= N_W'(sl);
      end
      if (cmd.hu_dn) begin
        hu <= SLOT_W'({cur, dn_idx});
      end
      if (cmd.hu_clear) begin
        hu <= '0;
      end
    end
  end

  // Working registers and result
  always_ff @(posedge clk) begin
    vr_q <= rvalid[cur];
    if (cmd.load_op) begin
      op <= in_item;
    end
    unique case (cmd.cur_op)
      bpsa_pkg::CUR_HOLD: cur <= cur;
      bpsa_pkg::CUR_HINT: cur <= hint_ix[GIDX_W-1:BIT_W];
      bpsa_pkg::CUR_OFS:  cur <= ofs[GIDX_W-1:BIT_W];
      bpsa_pkg::CUR_INC:  cur <= cur + ROW_W'(1);
      bpsa_pkg::CUR_DEC:  cur <= cur - ROW_W'(1);
      default:            cur <= cur;
    endcase
    if (cmd.sl_load) begin
      sl <= IX_W'(ofs);
    end
    if (cmd.ptr_load) begin
      ptr_q <= ptr_c;
    end
    if (cmd.res_load) begin
      unique case (cmd.res_kind)
        bpsa_pkg::RES_ALLOC_OK: out_item <= '{1'b1, alloc_addr, bpsa_pkg::ST_OK};
        bpsa_pkg::RES_FREE_OK:  out_item <= '{1'b1, '0, bpsa_pkg::ST_OK};
        bpsa_pkg::RES_CHECK_OK: out_item <= '{1'b1, ptr_q, bpsa_pkg::ST_OK};
        bpsa_pkg::RES_NO_SLOT:  out_item <= '{1'b0, '0, bpsa_pkg::ST_NO_SLOT};
        bpsa_pkg::RES_BAD_FREE: out_item <= '{1'b0, '0, bpsa_pkg::ST_BAD_FREE};
        default:                out_item <= '{1'b0, '0, bpsa_pkg::ST_REJECT};
      endcase
    end
  end

endmodule

// ===== hw/rtl/bitmap_page_slot_allocator_core.sv =====
// Top level of the bitmap page slot allocator: controller, datapath and assertions.
//
//   channel   signals                          handshake
//   request   start, busy, in_item (req_t)     taken when start && !busy
//   result    done, out_item (rsp_t)           one-cycle strobe, cannot be held off
//   config    cfg_we, cfg_addr, cfg_wdata      written when cfg_we, no wait, no read-back
//
// Bitmap RAM of 16-slot words (8 when MAX_SLOTS < 16), registered read. Alloc scans words up
// from the hint word; free tests the slot bit, then scans down for a new highest-used slot when
// the top slot is freed; check tests id limit and address, then reads the slot bit. Early rejects
// and unknown codes skip the bitmap. busy falls in the done cycle, where the next one may be taken.
// Reset (rst, synchronous) marks all slots available, clears hint and highest-used, loads defaults.
// Results are never stalled: each appears for exactly one cycle.
module bitmap_page_slot_allocator_core #(
  parameter int MAX_SLOTS  = bpsa_pkg::MAX_SLOTS_DEF,
  parameter int PAGE_SHIFT = bpsa_pkg::PAGE_SHIFT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  bpsa_pkg::req_t                 in_item,
  output logic                           done,
  output bpsa_pkg::rsp_t                 out_item,
  input  logic                           cfg_we,
  input  logic [bpsa_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [bpsa_pkg::ADDR_W-1:0]    cfg_wdata
);

  bpsa_pkg::cmd_t cmd;
  bpsa_pkg::sts_t sts;

  // Sequencer: one transaction at a time
  bpsa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (in_item.func),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Bitmap, hint, highest-used mark, config and address arithmetic
  bpsa_dp #(
    .MAX_SLOTS  (MAX_SLOTS),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_item  (out_item)
  );

`ifndef SYNTHESIS
  // A result only follows an accepted or running transaction
  a_done_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("result strobe without a transaction");

  // An accepted transaction is either running or answered in the next cycle
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted transaction vanished");

  // ok and status agree
  a_ok_status: assert property (@(posedge clk) disable iff (rst)
    done |-> (out_item.ok == (out_item.status == bpsa_pkg::ST_OK)))
    else $error("ok flag disagrees with status");

  // Failures carry a zero address
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !out_item.ok) |-> (out_item.result_addr == '0))
    else $error("failed transaction with non-zero address");
`endif

endmodule
